// File: src/pulse_rate_power_meter_macros.svh
// Assertion macros shared by the pulse rate power meter modules.
`ifndef PULSE_RATE_POWER_METER_MACROS_SVH
`define PULSE_RATE_POWER_METER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define PRPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define PRPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/prpm_pkg.sv
// Shared constants and types of the pulse rate power meter.
package prpm_pkg;

   localparam int STAMP_BITS  = 32;
   localparam int SCALE_BITS  = 32;
   localparam int POWER_BITS  = 32;
   localparam int COUNT_BITS  = 16;
   localparam int IDLE_BITS   = 8;
   localparam int IDLE_LIMIT  = 3;

   localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(17100000);

   // Division of a 32-bit stamp difference by 1000 as a multiply and shift.
   localparam int RECIP_BITS  = 29;
   localparam int RECIP_SHIFT = 38;
   localparam logic [RECIP_BITS-1:0] RECIP_1000 = RECIP_BITS'(274877907);
   localparam int MUL_BITS     = STAMP_BITS + RECIP_BITS;
   localparam int DIFF_MS_BITS = MUL_BITS - RECIP_SHIFT;

   // One extra bit so that the wrap allowance can be added without overflow.
   localparam int MS_BITS = DIFF_MS_BITS + 1;
   localparam logic [MS_BITS-1:0] WRAP_MS = MS_BITS'(4294967);

   localparam int PROD_BITS = SCALE_BITS + COUNT_BITS;
   localparam int STEP_BITS = $clog2(PROD_BITS);

   localparam int Q_DEPTH    = 2;
   localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

   // One computing tick, as the front hands it to the back.
   typedef struct packed {
      logic [STAMP_BITS-1:0] diff;
      logic                  wrap;
      logic [COUNT_BITS-1:0] cnt_m1;
   } job_type;

endpackage

// File: src/pulse_rate_power_meter.sv
// A computing tick passes through the multiply, a bit-serial division that
// gives one quotient bit per cycle over 48 bits, and the output register.
// Edge and idle-tick words are taken every cycle while the job queue is not
// full; computing ticks are limited by the bit-serial divider, which takes a
// new job only when idle, with a two-word job queue in front of it.
// Reset is synchronous: window state clears to zero, power_scale to 17100000.
module pulse_rate_power_meter
   import prpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [STAMP_BITS-1:0] req_stamp_us,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POWER_BITS-1:0] rsp_power_value,
   output logic                  rsp_zero_time_error,
   input  logic                  csr_wr_en,
   input  logic [SCALE_BITS-1:0] csr_wr_data
);

   logic [SCALE_BITS-1:0] scale_ff, scale_in;
   logic                  job_push;
   job_type               push_data;
   logic                  job_full;
   logic                  job_pop;
   logic                  job_valid;
   job_type               pop_data;

   assign scale_in = csr_wr_en ? csr_wr_data : scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else begin
         scale_ff <= scale_in;
      end
   end

   prpm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_stamp_us (req_stamp_us),
      .job_push     (job_push),
      .job_data     (push_data),
      .job_full     (job_full)
   );

   prpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .full      (job_full),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (pop_data)
   );

   prpm_back u_back (
      .clock               (clock),
      .reset               (reset),
      .power_scale         (scale_ff),
      .job_valid           (job_valid),
      .job_data            (pop_data),
      .job_pop             (job_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_power_value     (rsp_power_value),
      .rsp_zero_time_error (rsp_zero_time_error)
   );

endmodule

// File: src/prpm_front.sv
// Front part: takes edge and tick words, keeps the window state, issues jobs.
module prpm_front
   import prpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [STAMP_BITS-1:0] req_stamp_us,
   output logic                  job_push,
   output job_type               job_data,
   input  logic                  job_full
);

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [IDLE_BITS-1:0]  IDLE_MAX  = {IDLE_BITS{1'b1}};

   logic [STAMP_BITS-1:0] start_ff, start_in;
   logic [STAMP_BITS-1:0] latest_ff, latest_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [IDLE_BITS-1:0]  idle_ff, idle_in;
   logic                  accept;

   assign req_stall = job_full;
   assign accept    = req_valid & ~job_full;

   always_comb begin
      start_in          = start_ff;
      latest_in         = latest_ff;
      count_in          = count_ff;
      idle_in           = idle_ff;
      job_push          = 1'b0;
      job_data.diff     = latest_ff - start_ff;
      job_data.wrap     = (idle_ff > IDLE_BITS'(IDLE_LIMIT));
      job_data.cnt_m1   = count_ff - COUNT_BITS'(1);
      if (accept && !req_mode) begin
         latest_in = req_stamp_us;
         if (count_ff == '0) begin
            start_in = req_stamp_us;
         end
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_BITS'(1);
         end
      end else if (accept && req_mode) begin
         if (count_ff > COUNT_BITS'(1)) begin
            job_push = 1'b1;
            count_in = '0;
            idle_in  = '0;
         end else if (idle_ff != IDLE_MAX) begin
            idle_in = idle_ff + IDLE_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         latest_ff <= '0;
         count_ff  <= '0;
         idle_ff   <= '0;
      end else begin
         start_ff  <= start_in;
         latest_ff <= latest_in;
         count_ff  <= count_in;
         idle_ff   <= idle_in;
      end
   end

endmodule

// File: src/prpm_queue.sv
// Short job queue between the front and the back.
`include "pulse_rate_power_meter_macros.svh"

module prpm_queue
   import prpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output job_type pop_data
);

   job_type                mem_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0]  count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full      = (count_ff == Q_CNT_BITS'(Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                           : wr_ptr_ff + Q_PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
                                                           : rd_ptr_ff + Q_PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PRPM_ASSERT_NOW(a_push_not_full, clock, reset, push, !full, "job pushed into a full queue")
   `PRPM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= Q_CNT_BITS'(Q_DEPTH), "queue count above depth")
   `PRPM_ASSERT_NEXT(a_push_grows, clock, reset, push && !pop, count_ff == $past(count_ff) + Q_CNT_BITS'(1), "push without pop did not add a word")

endmodule

// File: src/prpm_back.sv
// Back part: forms the elapsed milliseconds and divides the scaled edge count less one.
`include "pulse_rate_power_meter_macros.svh"

module prpm_back
   import prpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [SCALE_BITS-1:0] power_scale,
   input  logic                  job_valid,
   input  job_type               job_data,
   output logic                  job_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [POWER_BITS-1:0] rsp_power_value,
   output logic                  rsp_zero_time_error
);

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_MUL  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [MUL_BITS-1:0]   recip_ff, recip_in;
   logic [PROD_BITS-1:0]  quot_ff, quot_in;
   logic                  wrap_ff, wrap_in;
   logic [MS_BITS-1:0]    divisor_ff, divisor_in;
   logic [MS_BITS-1:0]    rem_ff, rem_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic                  err_ff, err_in;
   logic                  out_valid_ff, out_valid_in;
   logic [POWER_BITS-1:0] out_power_ff, out_power_in;
   logic                  out_err_ff, out_err_in;

   logic [MS_BITS-1:0]    ms;
   logic [MS_BITS:0]      shifted;
   logic                  fits;
   logic                  slot_free;

   assign rsp_valid           = out_valid_ff;
   assign rsp_power_value     = out_power_ff;
   assign rsp_zero_time_error = out_err_ff;
   assign slot_free           = ~out_valid_ff | ~rsp_stall;

   always_comb begin
      ms = MS_BITS'(recip_ff[RECIP_SHIFT +: DIFF_MS_BITS]);
      if (wrap_ff) begin
         ms = ms + WRAP_MS;
      end
      shifted = {rem_ff, quot_ff[PROD_BITS-1]};
      fits    = (shifted >= {1'b0, divisor_ff});
   end

   always_comb begin
      state_in     = state_ff;
      recip_in     = recip_ff;
      quot_in      = quot_ff;
      wrap_in      = wrap_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      err_in       = err_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      out_power_in = out_power_ff;
      out_err_in   = out_err_ff;
      job_pop      = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               recip_in = MUL_BITS'(job_data.diff) * MUL_BITS'(RECIP_1000);
               quot_in  = PROD_BITS'(power_scale) * PROD_BITS'(job_data.cnt_m1);
               wrap_in  = job_data.wrap;
               state_in = B_MUL;
            end
         end
         B_MUL: begin
            if (ms == '0) begin
               // No time went by: report full scale and flag it.
               quot_in  = '1;
               err_in   = 1'b1;
               state_in = B_DONE;
            end else begin
               divisor_in = ms;
               rem_in     = '0;
               err_in     = 1'b0;
               step_in    = STEP_BITS'(PROD_BITS - 1);
               state_in   = B_DIV;
            end
         end
         B_DIV: begin
            rem_in  = fits ? MS_BITS'(shifted - {1'b0, divisor_ff}) : MS_BITS'(shifted);
            quot_in = {quot_ff[PROD_BITS-2:0], fits};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_power_in = (quot_ff[PROD_BITS-1:POWER_BITS] != '0) ? '1
                                                                     : quot_ff[POWER_BITS-1:0];
               out_err_in   = err_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      recip_ff     <= recip_in;
      quot_ff      <= quot_in;
      wrap_ff      <= wrap_in;
      divisor_ff   <= divisor_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      err_ff       <= err_in;
      out_power_ff <= out_power_in;
      out_err_ff   <= out_err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `PRPM_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == B_DIV, divisor_ff != '0, "division started with a zero divisor")
   `PRPM_ASSERT_NOW(a_err_saturates, clock, reset, out_valid_ff && out_err_ff, out_power_ff == '1, "zero time result not saturated")
   `PRPM_ASSERT_NOW(a_pop_when_idle, clock, reset, job_pop, state_ff == B_IDLE && job_valid, "job taken while busy")

endmodule
